[src/rpn_pkg.sv]
// Shared types, codes and defaults for the RPN stack evaluator.
package rpn_pkg;

    localparam int RPN_STACK_DEPTH = 16;
    localparam int RPN_DATA_WIDTH  = 32;
    localparam int RPN_QUEUE_DEPTH = 2;

    localparam logic REQ_OPERAND  = 1'b0;
    localparam logic REQ_OPERATOR = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_DIV_ZERO  = 2'd3
    } status_t;

    // Classified token as it travels from the front to the back
    typedef struct packed {
        logic start;
        logic is_push;
        logic iterative;
        op_t  op;
    } cmd_ctrl_t;

    // Request to the shared multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } iter_req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_ITER
    } back_state_t;

    typedef enum logic [1:0] {
        IT_IDLE,
        IT_RUN,
        IT_DONE
    } iter_state_t;

endpackage

[src/rpn_queue.sv]
// Small first-in first-out queue of registers.
module rpn_queue #(
    parameter int WIDTH = rpn_pkg::RPN_DATA_WIDTH,
    parameter int DEPTH = rpn_pkg::RPN_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    import rpn_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/rpn_front.sv]
// Front end: takes tokens, classifies them and queues them for the back end.
module rpn_front #(
    parameter int DATA_WIDTH  = rpn_pkg::RPN_DATA_WIDTH,
    parameter int QUEUE_DEPTH = rpn_pkg::RPN_QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    req_type,
    input  logic [DATA_WIDTH-1:0]   operand_value,
    input  logic [1:0]              op_code,
    input  logic                    start_expr,
    input  logic                    cmd_pop,
    output logic                    cmd_empty,
    output rpn_pkg::cmd_ctrl_t      cmd_ctrl,
    output logic [DATA_WIDTH-1:0]   cmd_value
);
    import rpn_pkg::*;

    localparam int CMD_W = $bits(cmd_ctrl_t) + DATA_WIDTH;

    cmd_ctrl_t        dec_ctrl;
    logic [CMD_W-1:0] q_wdata;
    logic [CMD_W-1:0] q_rdata;

    always_comb
    begin
        dec_ctrl.start     = start_expr;
        dec_ctrl.is_push   = (req_type == REQ_OPERAND);
        dec_ctrl.op        = op_t'(op_code);
        // multiply and divide go to the shared iterative unit
        dec_ctrl.iterative = (req_type == REQ_OPERATOR)
                             && (dec_ctrl.op == OP_MUL || dec_ctrl.op == OP_DIV);
    end

    assign q_wdata = {dec_ctrl, operand_value};

    rpn_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (q_wdata),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (q_rdata),
        .empty   (cmd_empty)
    );

    assign {cmd_ctrl, cmd_value} = q_rdata;

endmodule

[src/rpn_iter.sv]
// Shared radix-2 unit: shift-add multiply and restoring signed divide.
module rpn_iter #(
    parameter int DATA_WIDTH = rpn_pkg::RPN_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rpn_pkg::iter_req_t    req,
    input  logic [DATA_WIDTH-1:0] opa,
    input  logic [DATA_WIDTH-1:0] opb,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);
    import rpn_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    iter_state_t   state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    acc_reg, acc_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  d_reg, d_next;
    logic          div_reg, div_next;
    logic          neg_reg, neg_next;
    logic [W:0]    shifted;
    logic [W:0]    trial;
    logic [W-1:0]  mul_acc;

    assign shifted = {acc_reg[W-1:0], q_reg[W-1]};
    assign trial   = shifted - {1'b0, d_reg};
    assign mul_acc = {acc_reg[W-2:0], 1'b0} + (q_reg[W-1] ? d_reg : '0);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        done       = 1'b0;
        result     = div_reg ? (neg_reg ? (~q_reg + 1'b1) : q_reg) : acc_reg[W-1:0];
        unique case (state_reg)
            IT_IDLE:
            begin
                if (req.start)
                begin
                    div_next = req.is_div;
                    acc_next = '0;
                    cnt_next = CW'(W);
                    if (req.is_div)
                    begin
                        // work on magnitudes, restore the sign at the end
                        q_next   = opa[W-1] ? (~opa + 1'b1) : opa;
                        d_next   = opb[W-1] ? (~opb + 1'b1) : opb;
                        neg_next = opa[W-1] ^ opb[W-1];
                    end
                    else
                    begin
                        q_next   = opb;
                        d_next   = opa;
                        neg_next = 1'b0;
                    end
                    state_next = IT_RUN;
                end
            end
            IT_RUN:
            begin
                if (div_reg)
                begin
                    if (!trial[W])
                    begin
                        acc_next = trial;
                        q_next   = {q_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = shifted;
                        q_next   = {q_reg[W-2:0], 1'b0};
                    end
                end
                else
                begin
                    acc_next = {1'b0, mul_acc};
                    q_next   = {q_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = IT_DONE;
                end
            end
            IT_DONE:
            begin
                done       = 1'b1;
                state_next = IT_IDLE;
            end
            default:
            begin
                state_next = IT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IT_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

endmodule

[src/rpn_back.sv]
// Back end: value stack, depth tracking and execution of queued tokens.
module rpn_back #(
    parameter int STACK_DEPTH = rpn_pkg::RPN_STACK_DEPTH,
    parameter int DATA_WIDTH  = rpn_pkg::RPN_DATA_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_empty,
    output logic                             cmd_pop,
    input  rpn_pkg::cmd_ctrl_t               cmd_ctrl,
    input  logic [DATA_WIDTH-1:0]            cmd_value,
    input  logic                             res_full,
    output logic                             res_push,
    output logic [DATA_WIDTH-1:0]            res_top,
    output logic [$clog2(STACK_DEPTH+1)-1:0] res_depth,
    output rpn_pkg::status_t                 res_status
);
    import rpn_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];

    back_state_t           state_reg, state_next;
    logic [DW-1:0]         depth_reg, depth_next;
    logic [DATA_WIDTH-1:0] top_reg, top_next;
    op_t                   op_reg, op_next;
    logic                  iter_reg, iter_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    logic [DW-1:0]         eff_depth;
    logic [DATA_WIDTH-1:0] eff_top;
    logic [DW-1:0]         depth_m1;
    logic [DW-1:0]         depth_m2;
    logic [DATA_WIDTH-1:0] fast_result;

    iter_req_t             iter_req;
    logic                  iter_done;
    logic [DATA_WIDTH-1:0] iter_result;

    // a start flag empties the stack before the token is handled
    assign eff_depth   = cmd_ctrl.start ? '0 : depth_reg;
    assign eff_top     = (eff_depth == '0) ? '0 : top_reg;
    assign depth_m1    = depth_reg - DW'(1);
    assign depth_m2    = depth_reg - DW'(2);
    assign fast_result = (op_reg == OP_SUB) ? (rd_data_reg - top_reg)
                                            : (rd_data_reg + top_reg);

    rpn_iter #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (iter_req),
        .opa    (rd_data_reg),
        .opb    (top_reg),
        .done   (iter_done),
        .result (iter_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        top_next       = top_reg;
        op_next        = op_reg;
        iter_next      = iter_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res_top        = eff_top;
        res_depth      = eff_depth;
        res_status     = STAT_OK;
        wr_en          = 1'b0;
        wr_addr        = depth_m2[AW-1:0];
        wr_data        = fast_result;
        rd_en          = 1'b0;
        rd_addr        = depth_m2[AW-1:0];
        iter_req.start = 1'b0;
        iter_req.is_div = (op_reg == OP_DIV);
        unique case (state_reg)
            BK_IDLE:
            begin
                // take a word only when its result has room downstream
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop    = 1'b1;
                    depth_next = eff_depth;
                    if (cmd_ctrl.is_push)
                    begin
                        res_push = 1'b1;
                        if (eff_depth == DW'(STACK_DEPTH))
                        begin
                            res_status = STAT_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = eff_depth[AW-1:0];
                            wr_data    = cmd_value;
                            top_next   = cmd_value;
                            depth_next = eff_depth + 1'b1;
                            res_top    = cmd_value;
                            res_depth  = eff_depth + 1'b1;
                        end
                    end
                    else if (eff_depth < DW'(2))
                    begin
                        res_push   = 1'b1;
                        res_status = STAT_UNDERFLOW;
                    end
                    else if (cmd_ctrl.op == OP_DIV && top_reg == '0)
                    begin
                        res_push   = 1'b1;
                        res_status = STAT_DIV_ZERO;
                    end
                    else
                    begin
                        // fetch the left operand; the right one is the cached top
                        rd_en      = 1'b1;
                        op_next    = cmd_ctrl.op;
                        iter_next  = cmd_ctrl.iterative;
                        state_next = BK_FETCH;
                    end
                end
            end
            BK_FETCH:
            begin
                if (iter_reg)
                begin
                    iter_req.start = 1'b1;
                    state_next     = BK_ITER;
                end
                else
                begin
                    wr_en      = 1'b1;
                    top_next   = fast_result;
                    depth_next = depth_m1;
                    res_push   = 1'b1;
                    res_top    = fast_result;
                    res_depth  = depth_m1;
                    state_next = BK_IDLE;
                end
            end
            BK_ITER:
            begin
                if (iter_done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = iter_result;
                    top_next   = iter_result;
                    depth_next = depth_m1;
                    res_push   = 1'b1;
                    res_top    = iter_result;
                    res_depth  = depth_m1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            depth_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        op_reg   <= op_next;
        iter_reg <= iter_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

endmodule

[src/rpn_stack_evaluator_unit.sv]
// Top level of the RPN stack evaluator.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------------
//   token   | in  | push / full        | req_type, operand_value, op_code, start_expr
//   result  | out | pop / empty        | top_value, stack_depth, status
//
// Tokens are registered in the command queue on their way to the back end. Pushes
// and rejected tokens are settled in the idle state; add and subtract pass a fetch
// state, held by the registered read of the stack memory; multiply and divide then
// wait on the radix-2 iterative unit. The back end handles one token at a time and
// waits while the result queue is full. Reset empties both queues and the stack.
module rpn_stack_evaluator_unit #(
    parameter int STACK_DEPTH = rpn_pkg::RPN_STACK_DEPTH,
    parameter int DATA_WIDTH  = rpn_pkg::RPN_DATA_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             req_type,
    input  logic [DATA_WIDTH-1:0]            operand_value,
    input  logic [1:0]                       op_code,
    input  logic                             start_expr,
    output logic                             empty,
    input  logic                             pop,
    output logic [DATA_WIDTH-1:0]            top_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0] stack_depth,
    output logic [1:0]                       status
);
    import rpn_pkg::*;

    localparam int DW    = $clog2(STACK_DEPTH + 1);
    localparam int RES_W = DATA_WIDTH + DW + $bits(status_t);

    logic                  cmd_empty;
    logic                  cmd_pop;
    cmd_ctrl_t             cmd_ctrl;
    logic [DATA_WIDTH-1:0] cmd_value;
    logic                  res_full;
    logic                  res_push;
    logic [DATA_WIDTH-1:0] res_top;
    logic [DW-1:0]         res_depth;
    status_t               res_status;
    logic [RES_W-1:0]      res_wdata;
    logic [RES_W-1:0]      res_rdata;

    rpn_front #(
        .DATA_WIDTH  (DATA_WIDTH),
        .QUEUE_DEPTH (RPN_QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .operand_value (operand_value),
        .op_code       (op_code),
        .start_expr    (start_expr),
        .cmd_pop       (cmd_pop),
        .cmd_empty     (cmd_empty),
        .cmd_ctrl      (cmd_ctrl),
        .cmd_value     (cmd_value)
    );

    rpn_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .cmd_ctrl   (cmd_ctrl),
        .cmd_value  (cmd_value),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_top    (res_top),
        .res_depth  (res_depth),
        .res_status (res_status)
    );

    assign res_wdata = {res_top, res_depth, res_status};

    rpn_queue #(
        .WIDTH (RES_W),
        .DEPTH (RPN_QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wdata),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rdata),
        .empty   (empty)
    );

    assign {top_value, stack_depth, status} = res_rdata;

endmodule

[src/rpn_checker.sv]
// Port-level checks on the RPN stack evaluator, bound to the top level.
module rpn_checker #(
    parameter int STACK_DEPTH = rpn_pkg::RPN_STACK_DEPTH,
    parameter int DATA_WIDTH  = rpn_pkg::RPN_DATA_WIDTH
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             empty,
    input logic                             pop,
    input logic [DATA_WIDTH-1:0]            top_value,
    input logic [$clog2(STACK_DEPTH+1)-1:0] stack_depth,
    input logic [1:0]                       status
);
    import rpn_pkg::*;

    // an empty stack always reports a zero top
    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stack_depth == '0) |-> (top_value == '0))
        else $error("empty stack reported a nonzero top");

    a_underflow_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == STAT_UNDERFLOW) |-> (stack_depth < 2))
        else $error("underflow reported with two or more entries");

    a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == STAT_FULL) |-> (stack_depth == STACK_DEPTH))
        else $error("stack full reported below capacity");

    a_divzero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == STAT_DIV_ZERO) |-> (stack_depth >= 2))
        else $error("divide by zero reported without two operands");

    // a waiting result word holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(top_value) && $stable(stack_depth)
                              && $stable(status)))
        else $error("waiting result word changed before pop");

endmodule

bind rpn_stack_evaluator_unit rpn_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
) u_rpn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .top_value   (top_value),
    .stack_depth (stack_depth),
    .status      (status)
);

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the RPN evaluator: a directed token table, then random expressions.
module testbench;
    import rpn_pkg::*;

    localparam int DEPTH_MAX     = RPN_STACK_DEPTH;
    localparam int WIDTH         = RPN_DATA_WIDTH;
    localparam int DW            = $clog2(DEPTH_MAX + 1);
    localparam int RANDOM_TOKENS = 600;
    localparam int PAUSE_AT      = 300;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MOST_POS = ~MOST_NEG;

    typedef struct {
        logic             kind;
        logic [WIDTH-1:0] value;
        op_t              op;
        logic             start;
    } token_t;

    typedef struct {
        logic [WIDTH-1:0] top;
        logic [DW-1:0]    depth;
        status_t          code;
    } word_t;

    typedef struct {
        token_t tok;
        bit     typed;
        word_t  res;
    } row_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             push          = 1'b0;
    logic             req_type      = 1'b0;
    logic [WIDTH-1:0] operand_value = '0;
    logic [1:0]       op_code       = '0;
    logic             start_expr    = 1'b0;
    logic             pop           = 1'b0;
    logic             full;
    logic             empty;
    logic [WIDTH-1:0] top_value;
    logic [DW-1:0]    stack_depth;
    logic [1:0]       status;

    // Predictor state
    logic [WIDTH-1:0] shadow_stack [DEPTH_MAX];
    int               shadow_depth = 0;

    word_t expected_words [$];
    row_t  token_table [$];
    int    failures    = 0;
    int    cycle_count = 0;
    int    expr_left   = 0;
    bit    deep_expr   = 1'b0;

    rpn_stack_evaluator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .operand_value (operand_value),
        .op_code       (op_code),
        .start_expr    (start_expr),
        .empty         (empty),
        .pop           (pop),
        .top_value     (top_value),
        .stack_depth   (stack_depth),
        .status        (status)
    );

    always #10 clk = ~clk;

    function automatic word_t evaluate_token(input token_t t);
        word_t            w;
        status_t          code;
        logic [WIDTH-1:0] x;
        logic [WIDTH-1:0] y;
        logic [WIDTH-1:0] r;
        logic [WIDTH-1:0] mx;
        logic [WIDTH-1:0] my;
        logic [WIDTH-1:0] q;
        code = STAT_OK;
        if (t.start)
        begin
            shadow_depth = 0;
        end
        if (t.kind == REQ_OPERAND)
        begin
            if (shadow_depth >= DEPTH_MAX)
            begin
                code = STAT_FULL;
            end
            else
            begin
                shadow_stack[shadow_depth] = t.value;
                shadow_depth++;
            end
        end
        else if (shadow_depth < 2)
        begin
            code = STAT_UNDERFLOW;
        end
        else
        begin
            y = shadow_stack[shadow_depth-1];
            x = shadow_stack[shadow_depth-2];
            if (t.op == OP_DIV && y == '0)
            begin
                code = STAT_DIV_ZERO;
            end
            else
            begin
                case (t.op)
                    OP_ADD: r = x + y;
                    OP_SUB: r = x - y;
                    OP_MUL: r = x * y;
                    default:
                    begin
                        // divide magnitudes, then restore the sign: truncates toward zero
                        mx = x[WIDTH-1] ? ~x + 1'b1 : x;
                        my = y[WIDTH-1] ? ~y + 1'b1 : y;
                        q  = mx / my;
                        r  = (x[WIDTH-1] != y[WIDTH-1]) ? ~q + 1'b1 : q;
                    end
                endcase
                shadow_depth--;
                shadow_stack[shadow_depth-1] = r;
            end
        end
        w.top   = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
        w.depth = DW'(shadow_depth);
        w.code  = code;
        return w;
    endfunction

    function automatic void add_row(input logic kind, input logic [WIDTH-1:0] value,
                                    input op_t op, input logic start, input bit typed,
                                    input logic [WIDTH-1:0] top, input int depth,
                                    input status_t code);
        row_t r;
        r.tok.kind  = kind;
        r.tok.value = value;
        r.tok.op    = op;
        r.tok.start = start;
        r.typed     = typed;
        r.res.top   = top;
        r.res.depth = DW'(depth);
        r.res.code  = code;
        token_table.insert(token_table.size(), r);
    endfunction

    function automatic void build_table();
        logic [WIDTH-1:0] v;
        add_row(REQ_OPERAND,  MOST_POS, OP_ADD, 1'b1, 1, MOST_POS, 1, STAT_OK);
        add_row(REQ_OPERAND,  MOST_NEG, OP_ADD, 1'b0, 1, MOST_NEG, 2, STAT_OK);
        add_row(REQ_OPERATOR, '0,       OP_ADD, 1'b0, 1, '1,       1, STAT_OK);
        add_row(REQ_OPERATOR, '0,       OP_ADD, 1'b0, 1, '1,       1, STAT_UNDERFLOW);
        add_row(REQ_OPERAND,  '0,       OP_ADD, 1'b0, 1, '0,       2, STAT_OK);
        add_row(REQ_OPERATOR, '0,       OP_DIV, 1'b0, 1, '0,       2, STAT_DIV_ZERO);
        add_row(REQ_OPERATOR, '0,       OP_SUB, 1'b0, 1, '1,       1, STAT_OK);
        // most negative over minus one wraps back to most negative
        add_row(REQ_OPERAND,  MOST_NEG, OP_MUL, 1'b1, 1, MOST_NEG, 1, STAT_OK);
        add_row(REQ_OPERAND,  '1,       OP_SUB, 1'b0, 1, '1,       2, STAT_OK);
        add_row(REQ_OPERATOR, '0,       OP_DIV, 1'b0, 1, MOST_NEG, 1, STAT_OK);
        add_row(REQ_OPERAND,  -7,       OP_ADD, 1'b0, 0, '0,       0, STAT_OK);
        add_row(REQ_OPERATOR, '0,       OP_MUL, 1'b0, 0, '0,       0, STAT_OK);
        // operator together with start sees an empty stack
        add_row(REQ_OPERATOR, '1,       OP_MUL, 1'b1, 1, '0,       0, STAT_UNDERFLOW);
        v = '0;
        for (int i = 0; i < DEPTH_MAX; i++)
        begin
            v = i[0] ? MOST_POS - i : MOST_NEG + i;
            add_row(REQ_OPERAND, v, OP_ADD, (i == 0), 0, '0, 0, STAT_OK);
        end
        add_row(REQ_OPERAND, 32'h1234_5678, OP_DIV, 1'b0, 1, v, DEPTH_MAX, STAT_FULL);
    endfunction

    function automatic logic [WIDTH-1:0] draw_value();
        int v;
        v = $urandom_range(0, 16);
        case ($urandom_range(0, 7))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return '0;
            3, 4:    return WIDTH'(v - 8);
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed expressions, a tenth noise
    function automatic token_t draw_token();
        token_t t;
        int     depth_now;
        int     push_pct;
        t.value = draw_value();
        t.op    = op_t'($urandom_range(0, 3));
        t.start = 1'b0;
        if (expr_left == 0)
        begin
            expr_left = $urandom_range(1, 40);
            deep_expr = ($urandom_range(0, 3) == 0);
            t.start   = ($urandom_range(0, 7) != 0);
        end
        expr_left--;
        if ($urandom_range(0, 9) == 0)
        begin
            t.kind  = 1'($urandom_range(0, 1));
            t.start = t.start | ($urandom_range(0, 15) == 0);
            return t;
        end
        depth_now = t.start ? 0 : shadow_depth;
        push_pct  = deep_expr ? 85 : 50;
        if (depth_now < 2)
            t.kind = REQ_OPERAND;
        else if (depth_now >= DEPTH_MAX)
            t.kind = ($urandom_range(0, 3) == 0) ? REQ_OPERAND : REQ_OPERATOR;
        else
            t.kind = ($urandom_range(1, 100) <= push_pct) ? REQ_OPERAND : REQ_OPERATOR;
        return t;
    endfunction

    task automatic offer(input token_t t, input bit typed, input word_t typed_res);
        word_t w;
        push          <= 1'b1;
        req_type      <= t.kind;
        operand_value <= t.value;
        op_code       <= t.op;
        start_expr    <= t.start;
        do @(posedge clk); while (full !== 1'b0);
        w = evaluate_token(t);
        expected_words.insert(expected_words.size(), typed ? typed_res : w);
    endtask

    task automatic sender_gap(input bit calm, input bit drain);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (drain)
        begin
            // hold until every outstanding word has been read back
            push <= 1'b0;
            do @(posedge clk); while (expected_words.size() != 0);
        end
        else if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : token_side
        token_t t;
        word_t  unused;
        bit     calm;
        unused.top   = '0;
        unused.depth = '0;
        unused.code  = STAT_OK;
        calm   = 1'b0;
        build_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (token_table[i])
        begin
            offer(token_table[i].tok, token_table[i].typed, token_table[i].res);
            sender_gap(i >= 12, 1'b0);
        end
        for (int n = 0; n < RANDOM_TOKENS; n++)
        begin
            if (n % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            t = draw_token();
            offer(t, 1'b0, unused);
            sender_gap(calm, n == PAUSE_AT);
        end
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : result_side
        word_t want;
        int    gap;
        int    taken;
        bit    calm;
        taken = 0;
        calm  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 12);
            // hold pop low for a long stretch so the block backs up and raises full
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty !== 1'b0);
            taken++;
            if (expected_words.size() == 0)
            begin
                $error("word with nothing expected: top_value %h stack_depth %0d status %0d",
                       top_value, stack_depth, status);
                failures++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (top_value !== want.top)
                begin
                    $error("top_value: expected %h, got %h", want.top, top_value);
                    failures++;
                end
                if (stack_depth !== want.depth)
                begin
                    $error("stack_depth: expected %0d, got %0d", want.depth, stack_depth);
                    failures++;
                end
                if (status !== want.code)
                begin
                    $error("status: expected %0d, got %0d", want.code, status);
                    failures++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
